@@ design/bcpw_pkg.sv @@
// ----------------------------------------------------------------------------
// bcpw_pkg: shared types and constants for the binned coupling weight block
// Field widths, factor codes, the term factor table and pipeline sizes.
// ----------------------------------------------------------------------------
package bcpw_pkg;

   localparam int NUM_BINS_DEFAULT = 40;
   localparam int NUM_TERMS        = 23;
   localparam int COUPLING_W       = 24;
   localparam int COEF_W           = 32;
   localparam int MASS_W           = 16;
   localparam int BIN_W            = 6;
   localparam int SLOT_W           = 5;
   localparam int WEIGHT_W         = 48;
   localparam int TERM_W           = 125;  // 124-bit magnitude plus sign
   localparam int SUM_W            = 130;  // 23 terms summed exactly

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // binning: bin b has centre 250 + 20*b
   localparam int BIN_BASE  = 240;
   localparam int BIN_WIDTH = 20;
   localparam int LOW_EDGE  = 260;
   localparam int BIN_RECIP = 3277;   // ceil(2^16 / 20), exact below 800

   localparam logic signed [COUPLING_W-1:0] ONE_Q16 = 24'sd65536;

   localparam logic [2:0] FAC_KT  = 3'd0;
   localparam logic [2:0] FAC_KL  = 3'd1;
   localparam logic [2:0] FAC_C2  = 3'd2;
   localparam logic [2:0] FAC_CG  = 3'd3;
   localparam logic [2:0] FAC_C2G = 3'd4;
   localparam logic [2:0] FAC_ONE = 3'd5;

   localparam logic [2:0] TERM_FACTOR [NUM_TERMS][4] = '{
      '{FAC_KT,  FAC_KT,  FAC_KT,  FAC_KT },
      '{FAC_C2,  FAC_C2,  FAC_ONE, FAC_ONE},
      '{FAC_KT,  FAC_KT,  FAC_KL,  FAC_KL },
      '{FAC_CG,  FAC_CG,  FAC_KL,  FAC_KL },
      '{FAC_C2G, FAC_C2G, FAC_ONE, FAC_ONE},
      '{FAC_C2,  FAC_KT,  FAC_KT,  FAC_ONE},
      '{FAC_KT,  FAC_KT,  FAC_KT,  FAC_KL },
      '{FAC_KT,  FAC_KL,  FAC_C2,  FAC_ONE},
      '{FAC_CG,  FAC_KL,  FAC_C2,  FAC_ONE},
      '{FAC_C2,  FAC_C2G, FAC_ONE, FAC_ONE},
      '{FAC_CG,  FAC_KL,  FAC_KT,  FAC_KT },
      '{FAC_C2G, FAC_KT,  FAC_KT,  FAC_ONE},
      '{FAC_KT,  FAC_KL,  FAC_KL,  FAC_CG },
      '{FAC_C2G, FAC_KT,  FAC_KL,  FAC_ONE},
      '{FAC_CG,  FAC_C2G, FAC_KL,  FAC_ONE},
      '{FAC_CG,  FAC_KT,  FAC_KT,  FAC_KT },
      '{FAC_C2,  FAC_KT,  FAC_CG,  FAC_ONE},
      '{FAC_KT,  FAC_KL,  FAC_CG,  FAC_CG },
      '{FAC_KT,  FAC_CG,  FAC_C2G, FAC_ONE},
      '{FAC_KT,  FAC_KT,  FAC_CG,  FAC_CG },
      '{FAC_C2,  FAC_CG,  FAC_CG,  FAC_ONE},
      '{FAC_KL,  FAC_CG,  FAC_CG,  FAC_CG },
      '{FAC_C2G, FAC_CG,  FAC_CG,  FAC_ONE}
   };

   // pipeline: one read stage, lane stages, adder tree plus output stage
   localparam int TERM_STAGES = 7;
   localparam int SUM_STAGES  = 6;
   localparam int PIPE_DEPTH  = 1 + TERM_STAGES + SUM_STAGES;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

   typedef struct packed {
      logic                     en;
      logic [BIN_W-1:0]         bin;
      logic [SLOT_W-1:0]        slot;
      logic signed [COEF_W-1:0] value;
   } mem_wr_type;

   function automatic logic signed [COUPLING_W-1:0] factor_value(
      input logic [2:0]                   code,
      input logic signed [COUPLING_W-1:0] kt,
      input logic signed [COUPLING_W-1:0] kl,
      input logic signed [COUPLING_W-1:0] c2,
      input logic signed [COUPLING_W-1:0] cg,
      input logic signed [COUPLING_W-1:0] c2g
   );
      logic signed [COUPLING_W-1:0] val;
      case (code)
         FAC_KT:  val = kt;
         FAC_KL:  val = kl;
         FAC_C2:  val = c2;
         FAC_CG:  val = cg;
         FAC_C2G: val = c2g;
         default: val = ONE_Q16;
      endcase
      return val;
   endfunction

endpackage

@@ design/bcpw_if.sv @@
// ----------------------------------------------------------------------------
// bcpw_if: request and response channel interfaces
// Valid/ready channels carrying the request and response fields.
// ----------------------------------------------------------------------------
interface bcpw_req_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       command;
   logic [bcpw_pkg::MASS_W-1:0]                mass_gev;
   logic signed [bcpw_pkg::COUPLING_W-1:0]     top_coupling;
   logic signed [bcpw_pkg::COUPLING_W-1:0]     self_coupling;
   logic signed [bcpw_pkg::COUPLING_W-1:0]     contact_coupling;
   logic signed [bcpw_pkg::COUPLING_W-1:0]     gluon_coupling;
   logic signed [bcpw_pkg::COUPLING_W-1:0]     pair_gluon_coupling;
   logic [bcpw_pkg::BIN_W-1:0]                 load_bin;
   logic [bcpw_pkg::SLOT_W-1:0]                load_slot;
   logic signed [bcpw_pkg::COEF_W-1:0]         load_value;

   modport source (
      output valid, command, mass_gev, top_coupling, self_coupling, contact_coupling,
             gluon_coupling, pair_gluon_coupling, load_bin, load_slot, load_value,
      input  ready
   );
   modport sink (
      input  valid, command, mass_gev, top_coupling, self_coupling, contact_coupling,
             gluon_coupling, pair_gluon_coupling, load_bin, load_slot, load_value,
      output ready
   );
endinterface

interface bcpw_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [bcpw_pkg::WEIGHT_W-1:0]   weight;
   logic [bcpw_pkg::BIN_W-1:0]             mass_bin;
   logic                                   saturated;

   modport source (output valid, weight, mass_bin, saturated, input ready);
   modport sink   (input valid, weight, mass_bin, saturated, output ready);
endinterface

@@ design/bcpw_coef_mem.sv @@
// ----------------------------------------------------------------------------
// bcpw_coef_mem: coefficient table
// One row per mass bin, one coefficient written per load, full row read.
// ----------------------------------------------------------------------------
module bcpw_coef_mem #(
   parameter int NUM_BINS = bcpw_pkg::NUM_BINS_DEFAULT
) (
   input  logic                                                     clock,
   input  bcpw_pkg::mem_wr_type                                     wr,
   input  logic                                                     rd_en,
   input  logic [bcpw_pkg::BIN_W-1:0]                               rd_bin,
   output logic [bcpw_pkg::NUM_TERMS-1:0][bcpw_pkg::COEF_W-1:0]    rd_row
);
   localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

   logic [bcpw_pkg::NUM_TERMS-1:0][bcpw_pkg::COEF_W-1:0] mem_ff [NUM_BINS];
   logic [bcpw_pkg::NUM_TERMS-1:0][bcpw_pkg::COEF_W-1:0] rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.bin[AW-1:0]][wr.slot] <= wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem_ff[rd_bin[AW-1:0]];
      end
   end

   assign rd_row = rd_row_ff;
endmodule

@@ design/bcpw_term.sv @@
// ----------------------------------------------------------------------------
// bcpw_term: one polynomial term lane
// Exact signed product of a coefficient and four factors, seven stages.
// ----------------------------------------------------------------------------
module bcpw_term (
   input  logic                                        clock,
   input  logic [bcpw_pkg::TERM_STAGES-1:0]            ld,
   input  logic signed [bcpw_pkg::COEF_W-1:0]          coef,
   input  logic signed [bcpw_pkg::COUPLING_W-1:0]      factor [4],
   output logic signed [bcpw_pkg::TERM_W-1:0]          term
);
   localparam int CW = bcpw_pkg::COUPLING_W;

   logic [CW-1:0]  mag_ff [4];
   logic [31:0]    cmag_a_ff, cmag_b_ff, cmag_c_ff, cmag_d_ff;
   logic           neg_a_ff, neg_b_ff, neg_c_ff, neg_d_ff, neg_e_ff, neg_f_ff;
   logic [47:0]    p1_ff, p2_ff;
   logic [47:0]    pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [95:0]    q_ff;
   logic [63:0]    r0_ff, r1_ff, r2_ff;
   logic [127:0]   tmag_ff;
   logic signed [bcpw_pkg::TERM_W-1:0] term_ff;
   logic signed [bcpw_pkg::TERM_W-1:0] tpos;

   // sign and magnitude split
   always_ff @(posedge clock) begin
      if (ld[0]) begin
         for (int j = 0; j < 4; j++) begin
            mag_ff[j] <= factor[j][CW-1] ? CW'(-factor[j]) : CW'(factor[j]);
         end
         cmag_a_ff <= coef[31] ? 32'(-coef) : 32'(coef);
         neg_a_ff  <= coef[31] ^ factor[0][CW-1] ^ factor[1][CW-1]
                    ^ factor[2][CW-1] ^ factor[3][CW-1];
      end
   end

   // factor pairs
   always_ff @(posedge clock) begin
      if (ld[1]) begin
         p1_ff     <= 48'(mag_ff[0]) * 48'(mag_ff[1]);
         p2_ff     <= 48'(mag_ff[2]) * 48'(mag_ff[3]);
         cmag_b_ff <= cmag_a_ff;
         neg_b_ff  <= neg_a_ff;
      end
   end

   // pair times pair, 24-bit partial products
   always_ff @(posedge clock) begin
      if (ld[2]) begin
         pp00_ff   <= 48'(p1_ff[23:0])  * 48'(p2_ff[23:0]);
         pp01_ff   <= 48'(p1_ff[23:0])  * 48'(p2_ff[47:24]);
         pp10_ff   <= 48'(p1_ff[47:24]) * 48'(p2_ff[23:0]);
         pp11_ff   <= 48'(p1_ff[47:24]) * 48'(p2_ff[47:24]);
         cmag_c_ff <= cmag_b_ff;
         neg_c_ff  <= neg_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         q_ff      <= 96'(pp00_ff) + (96'(pp01_ff) << 24) + (96'(pp10_ff) << 24)
                    + (96'(pp11_ff) << 48);
         cmag_d_ff <= cmag_c_ff;
         neg_d_ff  <= neg_c_ff;
      end
   end

   // coefficient, 32-bit limbs
   always_ff @(posedge clock) begin
      if (ld[4]) begin
         r0_ff    <= 64'(q_ff[31:0])  * 64'(cmag_d_ff);
         r1_ff    <= 64'(q_ff[63:32]) * 64'(cmag_d_ff);
         r2_ff    <= 64'(q_ff[95:64]) * 64'(cmag_d_ff);
         neg_e_ff <= neg_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         tmag_ff  <= 128'(r0_ff) + (128'(r1_ff) << 32) + (128'(r2_ff) << 64);
         neg_f_ff <= neg_e_ff;
      end
   end

   assign tpos = $signed({1'b0, tmag_ff[bcpw_pkg::TERM_W-2:0]});

   always_ff @(posedge clock) begin
      if (ld[6]) begin
         term_ff <= neg_f_ff ? -tpos : tpos;
      end
   end

   assign term = term_ff;
endmodule

@@ design/bcpw_sum.sv @@
// ----------------------------------------------------------------------------
// bcpw_sum: term adder tree, rounding and saturation
// Five registered add levels, then round to Q32.16 and clip to 48 bits.
// ----------------------------------------------------------------------------
module bcpw_sum (
   input  logic                                      clock,
   input  logic [bcpw_pkg::SUM_STAGES-1:0]           ld,
   input  logic signed [bcpw_pkg::TERM_W-1:0]        term [bcpw_pkg::NUM_TERMS],
   output logic signed [bcpw_pkg::WEIGHT_W-1:0]      weight,
   output logic                                      saturated
);
   localparam int SW = bcpw_pkg::SUM_W;
   localparam int WW = bcpw_pkg::WEIGHT_W;
   localparam logic signed [SW-1:0] HALF = SW'(1) << 63;

   logic signed [SW-1:0] s1_ff [12];
   logic signed [SW-1:0] s2_ff [6];
   logic signed [SW-1:0] s3_ff [3];
   logic signed [SW-1:0] s4_ff [2];
   logic signed [SW-1:0] acc_ff;
   logic signed [SW-1:0] rounded;
   logic                 fits;
   logic signed [WW-1:0] weight_ff;
   logic                 saturated_ff;

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         for (int i = 0; i < 11; i++) begin
            s1_ff[i] <= SW'(term[2*i]) + SW'(term[2*i+1]);
         end
         s1_ff[11] <= SW'(term[22]);
      end
      if (ld[1]) begin
         for (int i = 0; i < 6; i++) begin
            s2_ff[i] <= s1_ff[2*i] + s1_ff[2*i+1];
         end
      end
      if (ld[2]) begin
         for (int i = 0; i < 3; i++) begin
            s3_ff[i] <= s2_ff[2*i] + s2_ff[2*i+1];
         end
      end
      if (ld[3]) begin
         s4_ff[0] <= s3_ff[0] + s3_ff[1];
         s4_ff[1] <= s3_ff[2];
      end
      if (ld[4]) begin
         acc_ff <= s4_ff[0] + s4_ff[1];
      end
   end

   // round half up at bit 63, keep bits 111:64
   assign rounded = acc_ff + HALF;
   assign fits    = (&rounded[SW-1:64+WW-1]) | ~(|rounded[SW-1:64+WW-1]);

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         if (fits) begin
            weight_ff <= rounded[64+WW-1:64];
         end else begin
            weight_ff <= rounded[SW-1] ? bcpw_pkg::WEIGHT_MIN : bcpw_pkg::WEIGHT_MAX;
         end
         saturated_ff <= ~fits;
      end
   end

   assign weight    = weight_ff;
   assign saturated = saturated_ff;
endmodule

@@ design/binned_coupling_polynomial_weight.sv @@
// ----------------------------------------------------------------------------
// binned_coupling_polynomial_weight: binned 23-term coupling polynomial
// Coefficient table per mass bin; evaluates a degree-4 polynomial per event.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle while ready is high, loads and
// evaluations alike. A load writes one coefficient into the table and
// produces no response; an evaluation produces one response after passing
// through the table row read, the term lanes (23 parallel multiplier lanes
// built from 24x24 and 32x32 partial products) and the adder tree with the
// final round-and-clip stage. The pipeline stalls stage by stage
// behind a held response, so bubbles are squeezed out and the request side
// keeps accepting until every stage is full. The table has no reset; an
// evaluation must only read coefficients that were loaded earlier. A load
// with a bin or slot outside the table is dropped.
// ----------------------------------------------------------------------------
module binned_coupling_polynomial_weight #(
   parameter int NUM_BINS = bcpw_pkg::NUM_BINS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   bcpw_req_if.sink     req_ch,
   bcpw_rsp_if.source   rsp_ch
);
   localparam int DEPTH = bcpw_pkg::PIPE_DEPTH;
   localparam int TS    = bcpw_pkg::TERM_STAGES;
   localparam int BW    = bcpw_pkg::BIN_W;
   localparam int CW    = bcpw_pkg::COUPLING_W;
   localparam logic [16:0] MASS_TOP =
      17'(bcpw_pkg::BIN_BASE + bcpw_pkg::BIN_WIDTH * NUM_BINS);

   // stage valids and per-stage load enables
   logic [DEPTH:1] v_ff;
   logic [DEPTH:1] ld;

   always_comb begin
      ld[DEPTH] = ~v_ff[DEPTH] | rsp_ch.ready;
      for (int k = DEPTH - 1; k >= 1; k--) begin
         ld[k] = ~v_ff[k] | ld[k+1];
      end
   end

   assign req_ch.ready = ld[1];

   logic eval_req;
   assign eval_req = req_ch.valid & (req_ch.command == bcpw_pkg::CMD_EVAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[1]) begin
            v_ff[1] <= eval_req;
         end
         for (int k = 2; k <= DEPTH; k++) begin
            if (ld[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // mass to bin: below 260 -> 0, past the last bin -> clamp,
   // else (mass - 240) / 20 by reciprocal multiply
   logic [9:0]    mass_off;
   logic [21:0]   bin_prod;
   logic [BW-1:0] bin_sel;

   assign mass_off = 10'(req_ch.mass_gev - 16'(bcpw_pkg::BIN_BASE));
   assign bin_prod = 22'(mass_off) * 22'(bcpw_pkg::BIN_RECIP);

   always_comb begin
      if (req_ch.mass_gev < 16'(bcpw_pkg::LOW_EDGE)) begin
         bin_sel = '0;
      end else if ({1'b0, req_ch.mass_gev} >= MASS_TOP) begin
         bin_sel = BW'(NUM_BINS - 1);
      end else begin
         bin_sel = bin_prod[21:16];
      end
   end

   logic [BW-1:0] bin_ff [DEPTH:1];

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         bin_ff[1] <= bin_sel;
      end
      for (int k = 2; k <= DEPTH; k++) begin
         if (ld[k]) begin
            bin_ff[k] <= bin_ff[k-1];
         end
      end
   end

   // coefficient table
   bcpw_pkg::mem_wr_type wr;
   logic [bcpw_pkg::NUM_TERMS-1:0][bcpw_pkg::COEF_W-1:0] rd_row;

   always_comb begin
      wr.en    = req_ch.valid & ld[1] & (req_ch.command == bcpw_pkg::CMD_LOAD)
               & (32'(req_ch.load_bin) < NUM_BINS)
               & (32'(req_ch.load_slot) < bcpw_pkg::NUM_TERMS);
      wr.bin   = req_ch.load_bin;
      wr.slot  = req_ch.load_slot;
      wr.value = req_ch.load_value;
   end

   bcpw_coef_mem #(.NUM_BINS(NUM_BINS)) u_mem (
      .clock  (clock),
      .wr     (wr),
      .rd_en  (ld[1] & eval_req),
      .rd_bin (bin_sel),
      .rd_row (rd_row)
   );

   // couplings ride alongside the row read
   logic signed [CW-1:0] kt_ff, kl_ff, c2_ff, cg_ff, c2g_ff;

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         kt_ff  <= req_ch.top_coupling;
         kl_ff  <= req_ch.self_coupling;
         c2_ff  <= req_ch.contact_coupling;
         cg_ff  <= req_ch.gluon_coupling;
         c2g_ff <= req_ch.pair_gluon_coupling;
      end
   end

   // term lanes
   logic signed [bcpw_pkg::TERM_W-1:0] term [bcpw_pkg::NUM_TERMS];

   for (genvar t = 0; t < bcpw_pkg::NUM_TERMS; t++) begin : g_lane
      logic signed [CW-1:0] fac [4];

      always_comb begin
         for (int j = 0; j < 4; j++) begin
            fac[j] = bcpw_pkg::factor_value(bcpw_pkg::TERM_FACTOR[t][j],
                                            kt_ff, kl_ff, c2_ff, cg_ff, c2g_ff);
         end
      end

      bcpw_term u_term (
         .clock  (clock),
         .ld     (ld[1+TS:2]),
         .coef   ($signed(rd_row[t])),
         .factor (fac),
         .term   (term[t])
      );
   end

   // sum, round, clip; last stage is the response register
   logic signed [bcpw_pkg::WEIGHT_W-1:0] weight;
   logic                                 saturated;

   bcpw_sum u_sum (
      .clock     (clock),
      .ld        (ld[DEPTH:2+TS]),
      .term      (term),
      .weight    (weight),
      .saturated (saturated)
   );

   assign rsp_ch.valid     = v_ff[DEPTH];
   assign rsp_ch.weight    = weight;
   assign rsp_ch.mass_bin  = bin_ff[DEPTH];
   assign rsp_ch.saturated = saturated;

   // request side only stalls with every stage full behind a held response
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> ((&v_ff) && !rsp_ch.ready))
      else $error("request stalled with a bubble in the pipeline");

   // a load never starts a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.command == bcpw_pkg::CMD_LOAD)
      |=> !v_ff[1])
      else $error("load transaction entered the pipeline");

   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (32'(rsp_ch.mass_bin) < NUM_BINS))
      else $error("response bin out of range");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.saturated) |->
      (rsp_ch.weight == bcpw_pkg::WEIGHT_MAX || rsp_ch.weight == bcpw_pkg::WEIGHT_MIN))
      else $error("saturated response not at a limit");
endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for binned_coupling_polynomial_weight
// Loads coefficient rows and checks weight, bin and clip flag of each
// evaluation against an exact wide-integer predictor.
// ----------------------------------------------------------------------------
module tb;

   localparam int NBINS      = bcpw_pkg::NUM_BINS_DEFAULT;
   localparam int NTERMS     = bcpw_pkg::NUM_TERMS;
   localparam int MW         = bcpw_pkg::MASS_W;
   localparam int CW         = bcpw_pkg::COUPLING_W;
   localparam int KW         = bcpw_pkg::COEF_W;
   localparam int WW         = bcpw_pkg::WEIGHT_W;
   localparam int BW         = bcpw_pkg::BIN_W;
   localparam int SLW        = bcpw_pkg::SLOT_W;
   localparam int CYCLE_MAX  = 200000;
   localparam int RAND_ITEMS = 1300;
   localparam int HOLD_LEN   = 400;   // long receiver hold-off, in cycles
   localparam int DRAIN_LEN  = 40;    // drain time beyond the pipeline

   typedef struct {
      logic                 command;
      logic [MW-1:0]        mass_gev;
      logic signed [CW-1:0] kt, kl, c2, cg, c2g;
      logic [BW-1:0]        load_bin;
      logic [SLW-1:0]       load_slot;
      logic signed [KW-1:0] load_value;
   } req_type;

   typedef struct {
      logic signed [WW-1:0] weight;
      logic [BW-1:0]        mass_bin;
      logic                 saturated;
   } weight_type;

   // ---------------------------------------------------------------------
   // Scoreboard: own copy of the coefficient table and an exact predictor
   // ---------------------------------------------------------------------
   class weight_scoreboard;
      logic signed [KW-1:0] coef [NBINS][NTERMS];
      weight_type pending_weights [$];
      int         mismatches;

      function logic signed [159:0] coupling_of(logic [2:0] code, req_type r);
         logic signed [159:0] v;
         case (code)
            bcpw_pkg::FAC_KT:  v = r.kt;
            bcpw_pkg::FAC_KL:  v = r.kl;
            bcpw_pkg::FAC_C2:  v = r.c2;
            bcpw_pkg::FAC_CG:  v = r.cg;
            bcpw_pkg::FAC_C2G: v = r.c2g;
            default:           v = 160'sd65536;
         endcase
         return v;
      endfunction

      function int pick_bin(logic [MW-1:0] m);
         int b;
         b = (m < bcpw_pkg::LOW_EDGE) ? 0
           : (int'(m) - bcpw_pkg::BIN_BASE) / bcpw_pkg::BIN_WIDTH;
         if (b > NBINS - 1) b = NBINS - 1;
         return b;
      endfunction

      // one accepted request transaction
      function void note_request(req_type r);
         logic signed [159:0] sum, term, lim;
         weight_type w;
         int b;
         if (r.command == bcpw_pkg::CMD_LOAD) begin
            if (r.load_bin < NBINS && r.load_slot < NTERMS)
               coef[r.load_bin][r.load_slot] = r.load_value;
            return;
         end
         b = pick_bin(r.mass_gev);
         sum = 0;
         for (int t = 0; t < NTERMS; t++) begin
            term = coef[b][t];
            for (int k = 0; k < 4; k++)
               term = term * coupling_of(bcpw_pkg::TERM_FACTOR[t][k], r);
            sum = sum + term;
         end
         // round half up at the Q.16 unit, then drop 64 fraction bits
         sum = (sum + (160'sd1 <<< 63)) >>> 64;
         lim = 160'sd1 <<< 47;
         w.mass_bin = BW'(b);
         w.saturated = 1'b1;
         if (sum >= lim)       w.weight = bcpw_pkg::WEIGHT_MAX;
         else if (sum < -lim)  w.weight = bcpw_pkg::WEIGHT_MIN;
         else begin
            w.weight = sum[WW-1:0];
            w.saturated = 1'b0;
         end
         pending_weights.push_back(w);
      endfunction

      // one accepted response transaction
      function void check_response(weight_type got);
         weight_type want;
         if (pending_weights.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: weight %h bin %0d sat %b",
                        got.weight, got.mass_bin, got.saturated);
            return;
         end
         want = pending_weights.pop_front();
         if (got.weight !== want.weight || got.mass_bin !== want.mass_bin ||
             got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: weight %h/%h bin %0d/%0d sat %b/%b (got/exp)",
                        got.weight, want.weight, got.mass_bin, want.mass_bin,
                        got.saturated, want.saturated);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles;
   int   rsp_count;
   bit   row_full [NBINS];
   bit   written [NBINS][NTERMS];
   weight_scoreboard sb;

   bcpw_req_if req_if ();
   bcpw_rsp_if rsp_if ();

   binned_coupling_polynomial_weight dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timeout watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_MAX) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // mostly short gaps, sometimes none for a while, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic logic signed [CW-1:0] rand_coupling();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return CW'($signed($urandom_range(0, 2**18)) - 2**17);
      if (r < 6) return ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
      return CW'($urandom);
   endfunction

   // mass that lands in bin b; the top bin also takes the clamped range
   function automatic logic [MW-1:0] mass_for_bin(int b);
      int lo;
      lo = bcpw_pkg::BIN_BASE + bcpw_pkg::BIN_WIDTH * b;
      if (b == 0) return MW'($urandom_range(0, bcpw_pkg::LOW_EDGE - 1));
      if (b == NBINS - 1) return ($urandom_range(0, 1) != 0) ?
         MW'($urandom_range(lo, 1100)) : MW'($urandom_range(lo, 65535));
      return MW'($urandom_range(lo, lo + bcpw_pkg::BIN_WIDTH - 1));
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: hold the transaction until accepted, then note it
   // ---------------------------------------------------------------------
   task automatic send(req_type r);
      req_if.valid               <= 1'b1;
      req_if.command             <= r.command;
      req_if.mass_gev            <= r.mass_gev;
      req_if.top_coupling        <= r.kt;
      req_if.self_coupling       <= r.kl;
      req_if.contact_coupling    <= r.c2;
      req_if.gluon_coupling      <= r.cg;
      req_if.pair_gluon_coupling <= r.c2g;
      req_if.load_bin            <= r.load_bin;
      req_if.load_slot           <= r.load_slot;
      req_if.load_value          <= r.load_value;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(r);
      if (r.command == bcpw_pkg::CMD_LOAD && r.load_bin < NBINS && r.load_slot < NTERMS)
      begin
         written[r.load_bin][r.load_slot] = 1'b1;
         row_full[r.load_bin] = 1'b1;
         for (int s = 0; s < NTERMS; s++)
            if (!written[r.load_bin][s]) row_full[r.load_bin] = 1'b0;
      end
   endtask

   task automatic pause(int n);
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // random filler for the fields the command ignores
   function automatic req_type noise_item();
      req_type r;
      r.command    = bcpw_pkg::CMD_LOAD;
      r.mass_gev   = MW'($urandom);
      r.kt         = CW'($urandom);
      r.kl         = CW'($urandom);
      r.c2         = CW'($urandom);
      r.cg         = CW'($urandom);
      r.c2g        = CW'($urandom);
      r.load_bin   = BW'($urandom);
      r.load_slot  = SLW'($urandom);
      r.load_value = KW'($urandom);
      return r;
   endfunction

   task automatic load_one(int b, int s, logic signed [KW-1:0] v);
      req_type r;
      r = noise_item();
      r.load_bin   = BW'(b);
      r.load_slot  = SLW'(s);
      r.load_value = v;
      send(r);
   endtask

   task automatic load_row(int b, int style);
      logic signed [KW-1:0] v;
      for (int s = 0; s < NTERMS; s++) begin
         case (style)
            0:       v = 32'sh7FFFFFFF;
            1:       v = 32'sh80000000;
            2:       v = KW'($signed($urandom_range(0, 2**20)) - 2**19);
            default: v = KW'($urandom);
         endcase
         load_one(b, s, v);
         pause(gap_len());
      end
   endtask

   task automatic evaluate(logic [MW-1:0] m, logic signed [CW-1:0] kt,
                           logic signed [CW-1:0] kl,
                           logic signed [CW-1:0] c2,
                           logic signed [CW-1:0] cg,
                           logic signed [CW-1:0] c2g);
      req_type r;
      r = noise_item();
      r.command  = bcpw_pkg::CMD_EVAL;
      r.mass_gev = m;
      r.kt = kt; r.kl = kl; r.c2 = c2; r.cg = cg; r.c2g = c2g;
      send(r);
   endtask

   // ---------------------------------------------------------------------
   // Response side: check on every accepted transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      weight_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.weight    = rsp_if.weight;
         got.mass_bin  = rsp_if.mass_bin;
         got.saturated = rsp_if.saturated;
         sb.check_response(got);
         rsp_count++;
      end
   end

   // ready: random stalls, plus one long hold-off while requests keep coming
   initial begin
      bit held;
      held = 1'b0;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         if (!held && rsp_count >= 150) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
         end else if (gap_len() > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int items, b, r;
      logic signed [CW-1:0] one, max_c, min_c;
      sb = new();
      rsp_count = 0;
      one   = bcpw_pkg::ONE_Q16;
      max_c = 24'sh7FFFFF;
      min_c = 24'sh800000;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.command <= bcpw_pkg::CMD_LOAD;
      req_if.mass_gev <= '0;
      req_if.top_coupling <= '0;
      req_if.self_coupling <= '0;
      req_if.contact_coupling <= '0;
      req_if.gluon_coupling <= '0;
      req_if.pair_gluon_coupling <= '0;
      req_if.load_bin <= '0;
      req_if.load_slot <= '0;
      req_if.load_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // rows at both ends with extreme coefficients, and a middle row of small ones
      load_row(0, 0);
      load_row(NBINS - 1, 1);
      load_row(20, 2);
      // loads outside the table are dropped
      load_one(NBINS, 0, 32'sh12345678);
      load_one(63, 31, 32'sh0BADF00D);
      load_one(5, NTERMS, 32'sh7FFFFFFF);

      // low mass, bin edges, high-mass clamp including exactly 1040
      evaluate(0,     one, one, one, one, one);
      evaluate(259,   one, one, one, one, one);
      evaluate(645,   one, one, 0, 0, 0);
      evaluate(1020,  one, one, one, one, one);
      evaluate(1040,  one, one, one, one, one);
      evaluate(65535, 0, 0, 0, 0, 0);
      // extreme couplings drive both saturation limits; then unit couplings with mixed signs
      evaluate(100,   max_c, max_c, max_c, max_c, max_c);
      evaluate(100,   min_c, min_c, min_c, min_c, min_c);
      evaluate(2000,  max_c, min_c, max_c, min_c, max_c);
      evaluate(2000,  min_c, max_c, min_c, max_c, min_c);
      evaluate(650,   one, one, one, one, one);
      evaluate(650,   -one, one, -one, one, -one);

      // random mix: whole rows loaded slot by slot, stray loads, evaluations of full rows
      items = 0;
      while (items < RAND_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            load_row($urandom_range(0, NBINS - 1), $urandom_range(2, 3));
            items += NTERMS;
         end else if (r < 22) begin
            if ($urandom_range(0, 3) == 0) send(noise_item());
            else load_one($urandom_range(0, NBINS - 1), $urandom_range(0, NTERMS - 1),
                          KW'($urandom));
            items++;
         end else begin
            do b = $urandom_range(0, NBINS - 1); while (!row_full[b]);
            evaluate(mass_for_bin(b), rand_coupling(), rand_coupling(), rand_coupling(),
                     rand_coupling(), rand_coupling());
            items++;
         end
         pause(gap_len());
      end
      req_if.valid <= 1'b0;

      while (sb.pending_weights.size() != 0) @(posedge clock);
      repeat (DRAIN_LEN) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending_weights.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/bcpw_pkg.sv
design/bcpw_if.sv
design/bcpw_coef_mem.sv
design/bcpw_term.sv
design/bcpw_sum.sv
design/binned_coupling_polynomial_weight.sv
test/tb.sv
